[rtl/rotary_axis_to_action_defines.svh]
// Assertion helpers for the top-level RTL file.
`ifndef ROTARY_AXIS_TO_ACTION_DEFINES_SVH
`define ROTARY_AXIS_TO_ACTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RATA_ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("rata assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RATA_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("rata assertion failed");

`endif

[rtl/rata_pkg.sv]
`default_nettype none
package rata_pkg;

    localparam int POS_W  = 16;
    localparam int IDX_W  = 4;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int PROD_W = 23;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_DETENT = 2'd1;
    localparam logic [1:0] MODE_BANDS  = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_RANGE  = 3'd1;
    localparam logic [2:0] REG_RISE   = 3'd2;
    localparam logic [2:0] REG_FALL   = 3'd3;
    localparam logic [2:0] REG_BOUNDS = 3'd4;

    localparam logic [IDX_W-1:0] ACT_RISE = 4'd0;
    localparam logic [IDX_W-1:0] ACT_FALL = 4'd1;

    localparam logic [6:0] PCT_FULL = 7'd100;

    typedef struct packed {
        logic [1:0]       mode;
        logic [POS_W-1:0] range;
        logic [7:0]       rise;
        logic [7:0]       fall;
        logic [63:0]      bounds;
    } cfg_t;

    typedef struct packed {
        logic fire;
        logic is_fall;
    } detent_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] band;
    } band_t;

endpackage
`default_nettype wire

[rtl/rata_channels.sv]
`default_nettype none
interface rata_sample_if;
    logic                        valid;
    logic                        ready;
    logic [rata_pkg::POS_W-1:0]  sample_pos;

    modport source (output valid, output sample_pos, input ready);
    modport sink   (input valid, input sample_pos, output ready);
endinterface

interface rata_result_if;
    logic                        valid;
    logic                        ready;
    logic                        fired;
    logic [rata_pkg::IDX_W-1:0]  action_index;

    modport source (output valid, output fired, output action_index, input ready);
    modport sink   (input valid, input fired, input action_index, output ready);
endinterface
`default_nettype wire

[rtl/rata_apb_regs.sv]
`default_nettype none
module rata_apb_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rata_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rata_pkg::DATA_W-1:0]  pwdata,
    output logic      [rata_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output rata_pkg::cfg_t                    cfg
);

    rata_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_sel;
    logic           wr_en;

    // Registers sit on 8-byte strides; low address bits are ignored.
    assign reg_sel = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                rata_pkg::REG_MODE:   cfg_reg.mode   <= pwdata[1:0];
                rata_pkg::REG_RANGE:  cfg_reg.range  <= pwdata[15:0];
                rata_pkg::REG_RISE:   cfg_reg.rise   <= pwdata[7:0];
                rata_pkg::REG_FALL:   cfg_reg.fall   <= pwdata[7:0];
                rata_pkg::REG_BOUNDS: cfg_reg.bounds <= pwdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            rata_pkg::REG_MODE:   prdata = {62'd0, cfg_reg.mode};
            rata_pkg::REG_RANGE:  prdata = {48'd0, cfg_reg.range};
            rata_pkg::REG_RISE:   prdata = {56'd0, cfg_reg.rise};
            rata_pkg::REG_FALL:   prdata = {56'd0, cfg_reg.fall};
            rata_pkg::REG_BOUNDS: prdata = cfg_reg.bounds;
            default:              prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/rata_detent.sv]
`default_nettype none
module rata_detent (
    input  wire rata_pkg::cfg_t               cfg,
    input  wire logic [rata_pkg::POS_W-1:0]   held,
    input  wire logic [rata_pkg::POS_W-1:0]   pos,
    output rata_pkg::detent_t                 result
);

    logic [rata_pkg::POS_W:0] held_x;
    logic [rata_pkg::POS_W:0] pos_x;
    logic [rata_pkg::POS_W:0] held_plus_rise;
    logic [rata_pkg::POS_W:0] pos_plus_fall;
    logic                     rising;

    // Compare in 17 bits so that no sum wraps.
    assign held_x         = {1'b0, held};
    assign pos_x          = {1'b0, pos};
    assign held_plus_rise = held_x + {9'd0, cfg.rise};
    assign pos_plus_fall  = pos_x + {9'd0, cfg.fall};
    assign rising         = pos > held;

    always_comb
    begin
        result.is_fall = !rising;
        if (rising)
        begin
            result.fire = (held_plus_rise < {1'b0, cfg.range}) && (pos_x > held_plus_rise);
        end
        else
        begin
            result.fire = (held > {8'd0, cfg.fall}) && (pos_plus_fall < held_x);
        end
    end

endmodule
`default_nettype wire

[rtl/rata_band_lookup.sv]
`default_nettype none
module rata_band_lookup #(
    parameter int BAND_SLOTS = 8
) (
    input  wire rata_pkg::cfg_t               cfg,
    input  wire logic [rata_pkg::POS_W-1:0]   pos,
    output rata_pkg::band_t                   result
);

    // pos < floor(p*range/100)  <=>  100*(pos+1) <= p*range,
    // so each slot needs one narrow product and one compare.
    logic [rata_pkg::PROD_W-1:0] pos_scaled;
    logic [rata_pkg::PROD_W-1:0] prod  [BAND_SLOTS];
    logic [BAND_SLOTS-1:0]       below;
    logic [BAND_SLOTS-1:0]       term;
    logic [6:0]                  pct   [BAND_SLOTS];

    assign pos_scaled = ({7'd0, pos} + 23'd1) * 23'd100;

    always_comb
    begin
        for (int i = 0; i < BAND_SLOTS; i++)
        begin
            term[i]  = (cfg.bounds[8*i +: 8] == 8'd0) || (cfg.bounds[8*i +: 8] >= 8'd100);
            pct[i]   = term[i] ? rata_pkg::PCT_FULL : cfg.bounds[8*i +: 7];
            prod[i]  = {16'd0, pct[i]} * {7'd0, cfg.range};
            below[i] = pos_scaled <= prod[i];
        end
    end

    always_comb
    begin
        logic done;
        logic at_prev;
        done         = 1'b0;
        result.found = 1'b0;
        result.band  = '0;
        for (int i = 0; i < BAND_SLOTS; i++)
        begin
            at_prev = (i == 0) ? 1'b1 : !below[(i == 0) ? 0 : i - 1];
            if (!done)
            begin
                if (at_prev && below[i])
                begin
                    done         = 1'b1;
                    result.found = 1'b1;
                    result.band  = rata_pkg::IDX_W'(i);
                end
                else if (term[i])
                begin
                    done         = 1'b1;
                    result.found = at_prev;
                    result.band  = rata_pkg::IDX_W'(i);
                end
            end
        end
        // No terminator: anything at or above the last bound is the top band.
        if (!done && !below[BAND_SLOTS-1])
        begin
            result.found = 1'b1;
            result.band  = rata_pkg::IDX_W'(BAND_SLOTS);
        end
    end

endmodule
`default_nettype wire

[rtl/rotary_axis_to_action.sv]
// Channel      Dir  Payload                     Handshake
// sample_in    in   sample_pos[15:0]            valid/ready
// result_out   out  fired, action_index[3:0]    valid/ready
// apb          in   paddr[5:0], pwdata[63:0]    psel/penable/pwrite, pready = 1
//
// One item per cycle sustained while result_out is ready; an accepted sample waits in the input
// register until the result stage is free or draining, then loads it and sets result_out.valid.
// Held position and current band update when a sample moves to the result register.
// rst_n is asynchronous: clears the valid flags, held position and band.
// A stalled result_out holds its item; the input register still takes one more item.
`default_nettype none
`include "rotary_axis_to_action_defines.svh"
module rotary_axis_to_action #(
    parameter int BAND_SLOTS = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rata_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rata_pkg::DATA_W-1:0]  pwdata,
    output logic      [rata_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    rata_sample_if.sink                       sample_in,
    rata_result_if.source                     result_out
);

    rata_pkg::cfg_t    cfg;
    rata_pkg::detent_t det;
    rata_pkg::band_t   band;

    // Input stage.
    logic                        in_valid_reg;
    logic [rata_pkg::POS_W-1:0]  pos_reg;

    // Result stage.
    logic                        out_valid_reg;
    logic                        fired_reg;
    logic [rata_pkg::IDX_W-1:0]  action_reg;

    // Axis state.
    logic [rata_pkg::POS_W-1:0]  held_reg;
    logic [rata_pkg::POS_W-1:0]  held_next;
    logic [rata_pkg::IDX_W-1:0]  zone_reg;
    logic [rata_pkg::IDX_W-1:0]  zone_next;

    logic                        fired_next;
    logic [rata_pkg::IDX_W-1:0]  action_next;
    logic                        advance;
    logic                        take_in;

    // Whether the result register holds a fired band item or a fired detent item.
    logic                        zone_event;
    logic                        det_event;

    rata_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rata_detent u_detent (
        .cfg    (cfg),
        .held   (held_reg),
        .pos    (pos_reg),
        .result (det)
    );

    rata_band_lookup #(
        .BAND_SLOTS (BAND_SLOTS)
    ) u_bands (
        .cfg    (cfg),
        .pos    (pos_reg),
        .result (band)
    );

    // Advance the input item when the result register is free or being drained.
    assign advance          = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign sample_in.ready  = !in_valid_reg || advance;
    assign take_in          = sample_in.valid && sample_in.ready;

    assign result_out.valid        = out_valid_reg;
    assign result_out.fired        = fired_reg;
    assign result_out.action_index = action_reg;

    // Decide the action for the item in the input register.
    always_comb
    begin
        fired_next  = 1'b0;
        action_next = '0;
        held_next   = held_reg;
        zone_next   = zone_reg;
        case (cfg.mode)
            rata_pkg::MODE_DETENT:
            begin
                if (det.fire)
                begin
                    fired_next  = 1'b1;
                    action_next = det.is_fall ? rata_pkg::ACT_FALL : rata_pkg::ACT_RISE;
                    held_next   = pos_reg;
                end
            end
            rata_pkg::MODE_BANDS:
            begin
                if (band.found && (band.band != zone_reg))
                begin
                    fired_next  = 1'b1;
                    action_next = band.band;
                    zone_next   = band.band;
                end
            end
            default:
            begin
                // Off or unused mode: pass the sample on with no action.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            zone_reg      <= '0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                held_reg      <= held_next;
                zone_reg      <= zone_next;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            pos_reg <= sample_in.sample_pos;
        end
        if (advance)
        begin
            fired_reg  <= fired_next;
            action_reg <= action_next;
        end
    end

    assign zone_event = out_valid_reg && fired_reg && (action_reg == zone_reg);
    assign det_event  = out_valid_reg && fired_reg
                        && (action_reg == rata_pkg::ACT_RISE || action_reg == rata_pkg::ACT_FALL);

    `RATA_ASSERT_NEXT(a_advance_loads, clk, rst_n, advance, out_valid_reg)
    `RATA_ASSERT_IMPLY(a_zone_change_fires, clk, rst_n, zone_reg != $past(zone_reg), zone_event)
    `RATA_ASSERT_IMPLY(a_held_change_fires, clk, rst_n, held_reg != $past(held_reg), det_event)

endmodule
`default_nettype wire

[tb/sv/rotary_axis_to_action_test.sv]
`default_nettype none
module rotary_axis_to_action_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rata_pkg::*;

    localparam int BAND_SLOTS   = 8;
    localparam int RANDOM_ITEMS = 1050;
    // Mode code that the block treats like the off mode.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // One result item: did the sample fire, and which action.
    typedef struct packed {
        logic             fired;
        logic [IDX_W-1:0] action_index;
    } axis_event_t;

    logic clk;
    logic rst_n = 1'b0;

    // APB side, driven from the stimulus process only.
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Channel drive registers; the interfaces take them by continuous assignment.
    logic             drv_valid = 1'b0;
    logic [POS_W-1:0] drv_pos   = '0;
    logic             mon_ready = 1'b0;

    rata_sample_if sample_ch ();
    rata_result_if result_ch ();

    assign sample_ch.valid      = drv_valid;
    assign sample_ch.sample_pos = drv_pos;
    assign result_ch.ready      = mon_ready;

    rotary_axis_to_action #(
        .BAND_SLOTS (BAND_SLOTS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample_in  (sample_ch),
        .result_out (result_ch)
    );

    // Shadow copy of the register file and of the block state.
    logic [1:0]       mode_cfg   = MODE_OFF;
    logic [POS_W-1:0] range_cfg  = '0;
    logic [7:0]       rise_cfg   = '0;
    logic [7:0]       fall_cfg   = '0;
    logic [63:0]      bounds_cfg = '0;
    logic [POS_W-1:0] held_pos   = '0;
    logic [IDX_W-1:0] zone_now   = '0;

    logic [POS_W-1:0] pending_samples[$];
    axis_event_t      expected_events[$];

    int send_idle_pct  = 13;
    int recv_idle_pct  = 75;
    int mismatch_count = 0;
    int accepted_count = 0;
    int fired_count    = 0;
    int settings_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Band lookup: scan the percent bytes, a byte of 0 or >= 100 closes the
    // list at full scale after its own test. Returns -1 when no band holds pos.
    function automatic int band_of(input logic [POS_W-1:0] pos);
        int  prev;
        int  slot;
        int  pct;
        int  bound;
        int  pos_i;
        bit  closing;
        prev  = 0;
        slot  = 0;
        pos_i = pos;
        while (slot < BAND_SLOTS)
        begin
            pct     = bounds_cfg[8*slot +: 8];
            closing = (pct == 0) || (pct >= PCT_FULL);
            if (closing)
                pct = PCT_FULL;
            bound = (pct * int'(range_cfg)) / 100;
            if (pos_i >= prev && pos_i < bound)
                return slot;
            if (closing)
                break;
            prev = bound;
            slot++;
        end
        if (pos_i >= prev)
            return slot;
        return -1;
    endfunction

    // Advance the shadow state by one accepted sample and queue its result.
    function automatic void predict_event(input logic [POS_W-1:0] pos);
        axis_event_t ev;
        int          held_i;
        int          pos_i;
        int          tough;
        int          band;
        ev     = '0;
        held_i = held_pos;
        pos_i  = pos;
        if (mode_cfg == MODE_DETENT)
        begin
            if (pos_i > held_i)
            begin
                // Rise: compared without wrap, so a toughness above the
                // range never lets it fire.
                tough = rise_cfg;
                if (held_i < int'(range_cfg) - tough && pos_i > held_i + tough)
                begin
                    held_pos        = pos;
                    ev.fired        = 1'b1;
                    ev.action_index = ACT_RISE;
                end
            end
            else
            begin
                tough = fall_cfg;
                if (held_i > tough && pos_i < held_i - tough)
                begin
                    held_pos        = pos;
                    ev.fired        = 1'b1;
                    ev.action_index = ACT_FALL;
                end
            end
        end
        else if (mode_cfg == MODE_BANDS)
        begin
            band = band_of(pos);
            if (band >= 0 && band != int'(zone_now))
            begin
                zone_now        = band[IDX_W-1:0];
                ev.fired        = 1'b1;
                ev.action_index = band[IDX_W-1:0];
            end
        end
        expected_events.push_back(ev);
    endfunction

    // Sample driver: on an accepted item predict its result, then present
    // the next pending sample unless this cycle is an idle one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (drv_valid && sample_ch.ready)
            begin
                predict_event(drv_pos);
                accepted_count++;
            end
            if (!drv_valid || sample_ch.ready)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_pos   <= pending_samples.pop_front();
                    drv_valid <= 1'b1;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: match every accepted result against the oldest
    // expectation, then pick the ready level for the next cycle.
    always @(posedge clk)
    begin
        axis_event_t want;
        if (rst_n)
        begin
            if (result_ch.valid && mon_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual fired=%0b action=%0d",
                             $time, result_ch.fired, result_ch.action_index);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (result_ch.fired !== want.fired)
                    begin
                        $display("%0t: fired mismatch: expected %0b, actual %0b",
                                 $time, want.fired, result_ch.fired);
                        mismatch_count++;
                    end
                    if (result_ch.action_index !== want.action_index)
                    begin
                        $display("%0t: action_index mismatch: expected %0d, actual %0d",
                                 $time, want.action_index, result_ch.action_index);
                        mismatch_count++;
                    end
                    if (want.fired)
                        fired_count++;
                end
            end
            mon_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // APB write: setup cycle, then access until pready; mirror into the shadow.
    task automatic write_register(input logic [2:0] index, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_MODE:   mode_cfg   = value[1:0];
            REG_RANGE:  range_cfg  = value[POS_W-1:0];
            REG_RISE:   rise_cfg   = value[7:0];
            REG_FALL:   fall_cfg   = value[7:0];
            REG_BOUNDS: bounds_cfg = value;
            default:    ;
        endcase
    endtask

    // Hold until every queued sample went in and every result came out.
    task automatic wait_drained();
        while (pending_samples.size() > 0 || drv_valid || expected_events.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Drain, then load a full register setting.
    task automatic apply_settings(input logic [1:0] mode, input logic [15:0] range,
                                  input logic [7:0] rise, input logic [7:0] fall,
                                  input logic [63:0] bounds);
        wait_drained();
        write_register(REG_MODE, {62'd0, mode});
        write_register(REG_RANGE, {48'd0, range});
        write_register(REG_RISE, {56'd0, rise});
        write_register(REG_FALL, {56'd0, fall});
        write_register(REG_BOUNDS, bounds);
        settings_count++;
    endtask

    // Percent lists: rising runs with an optional closing byte, unordered
    // lists, or raw random words.
    function automatic logic [63:0] random_bounds();
        logic [63:0] packed_pct;
        int          pct;
        int          stop_at;
        int          style;
        packed_pct = '0;
        pct        = 0;
        stop_at    = $urandom_range(8);
        style      = $urandom_range(3);
        if (style == 2)
            return {$urandom, $urandom};
        for (int i = 0; i < 8; i++)
        begin
            if (i == stop_at)
                packed_pct[8*i +: 8] = $urandom_range(1) ? 8'd0 : 8'($urandom_range(100, 255));
            else if (style == 3)
                packed_pct[8*i +: 8] = 8'($urandom_range(1, 99));
            else
            begin
                pct += $urandom_range(1, 20);
                if (pct > 99)
                    pct = 99;
                packed_pct[8*i +: 8] = 8'(pct);
            end
        end
        return packed_pct;
    endfunction

    function automatic logic [7:0] random_toughness();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return 8'd0;
        if (pick < 30)
            return 8'd255;
        if (pick < 60)
            return 8'($urandom_range(1, 16));
        return 8'($urandom_range(255));
    endfunction

    initial
    begin
        int               random_items;
        int               count;
        int               walk;
        int               span;
        int               pick;
        logic [1:0]       mode;
        logic [15:0]      range;
        logic [7:0]       rise;
        logic [7:0]       fall;
        logic [POS_W-1:0] last_pos;

        random_items = 0;
        last_pos     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Detents: rise, small rise below toughness, fall, full-scale jumps.
        apply_settings(MODE_DETENT, 16'd1000, 8'd10, 8'd10, 64'd0);
        pending_samples.push_back(16'd500);
        pending_samples.push_back(16'd505);
        pending_samples.push_back(16'd511);
        pending_samples.push_back(16'd500);
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'd0);
        pending_samples.push_back(16'd5);

        // Toughness above the range: rising can never fire.
        apply_settings(MODE_DETENT, 16'd100, 8'd255, 8'd0, 64'd0);
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'd0);

        // Unused mode code: nothing fires, state stays.
        apply_settings(MODE_UNUSED, 16'hFFFF, 8'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        pending_samples.push_back(16'd0);
        pending_samples.push_back(16'hFFFF);

        // Eight open slots, no closing byte: top band is index 8.
        apply_settings(MODE_BANDS, 16'hFFFF, 8'd0, 8'd0, 64'h5046_3C32_281E_140A);
        pending_samples.push_back(16'd0);
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'd6553);
        pending_samples.push_back(16'd6552);
        pending_samples.push_back(16'd6552);

        // Falling bounds, closed by a byte of exactly 100.
        apply_settings(MODE_BANDS, 16'hFFFF, 8'd0, 8'd0, 64'h0000_0000_0064_2832);
        pending_samples.push_back(16'd40000);
        pending_samples.push_back(16'd30000);

        // Closing byte above 100, then a list closed at once by a zero byte.
        apply_settings(MODE_BANDS, 16'd1000, 8'd0, 8'd0, 64'h0000_0000_0000_FF19);
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'd0);
        apply_settings(MODE_BANDS, 16'd1000, 8'd0, 8'd0, 64'd0);
        pending_samples.push_back(16'd999);

        // Zero range: every bound collapses to zero.
        apply_settings(MODE_BANDS, 16'd0, 8'd0, 8'd0, 64'h5046_3C32_281E_140A);
        pending_samples.push_back(16'd1234);

        // Random phases: each draws a setting, then a batch of samples that
        // suits the mode so detents and band changes actually happen.
        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                mode = MODE_DETENT;
            else if (pick < 90)
                mode = MODE_BANDS;
            else if (pick < 95)
                mode = MODE_OFF;
            else
                mode = MODE_UNUSED;
            pick = $urandom_range(99);
            if (pick < 20)
                range = 16'hFFFF;
            else if (pick < 30)
                range = 16'd0;
            else if (pick < 45)
                range = 16'($urandom_range(1, 600));
            else
                range = 16'($urandom);
            rise = random_toughness();
            fall = random_toughness();
            apply_settings(mode, range, rise, fall, random_bounds());

            // Drop idling in thirds: slow receiver, then slow sender, then none.
            if (random_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 13;
                recv_idle_pct = 75;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 13;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            count = $urandom_range(30, 90);
            walk  = $urandom_range(int'(range));
            span  = 2 * ((rise > fall) ? int'(rise) : int'(fall)) + 8;
            repeat (count)
            begin
                pick = $urandom_range(99);
                if (pick < 15 || mode == MODE_OFF || mode == MODE_UNUSED)
                    last_pos = 16'($urandom);
                else if (mode == MODE_DETENT)
                begin
                    // Random walk around the held position region.
                    walk = walk + $urandom_range(2 * span) - span;
                    if (walk < 0)
                        walk = 0;
                    if (walk > 65535)
                        walk = 65535;
                    last_pos = 16'(walk);
                end
                else if (pick < 30)
                    ; // repeat the previous sample: same band, no change
                else
                    last_pos = 16'($urandom_range(int'(range)));
                pending_samples.push_back(last_pos);
                random_items++;
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_events.size() > 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_events.size());
            mismatch_count++;
        end
        $display("Ran %0d samples through %0d register settings, %0d actions fired.",
                 accepted_count, settings_count, fired_count);
        $display("Modes off, detent, bands and unused; idling on sender, receiver, neither.");
        if (mismatch_count == 0)
            $display("[rotary_axis_to_action] OK");
        else
            $display("[rotary_axis_to_action] ERROR");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Timeout: %0d results still expected", expected_events.size());
        $display("[rotary_axis_to_action] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
